// ----- hw/rtl/weighted_union_find_assert.svh -----
// Assertion macros shared by the RTL of the union-find engine.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef WEIGHTED_UNION_FIND_ASSERT_SVH
`define WEIGHTED_UNION_FIND_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WUF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("union-find check failed");

// Next-cycle implication, disabled during reset.
`define WUF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("union-find check failed");

`endif

// ----- hw/rtl/wuf_pkg.sv -----
// Types and constants of the union-find engine.
// No dependencies; imported by the top level.
package wuf_pkg;

   localparam int NODE_W  = 10;   // width of a node index field
   localparam int SIZE_W  = 11;   // tree size, at most 1024 nodes reachable
   localparam int COUNT_W = 11;   // node_count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic KIND_UNION = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_WALK_A = 7'b0000100,
      ST_WALK_B = 7'b0001000,
      ST_SIZE_A = 7'b0010000,
      ST_SIZE_B = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

endpackage

// ----- hw/rtl/wuf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the parent-link and tree-size stores.
module wuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/weighted_union_find.sv -----
// Top level of the weighted quick-union disjoint-set engine.
// Depends on wuf_pkg, wuf_ram and weighted_union_find_assert.svh.
//
// Channel  Dir  Contents
// req_     in   tdata: first_node, second_node; tuser: kind
// rsp_     out  tdata: same_set, range_error
// csr_     in   APB write/read of node_count (single register, address not decoded)
//
// An item is taken in the idle state and walks from each node to its root;
// a linking union then reads both tree sizes and writes the link. An item
// out of range skips to the result stage, where every item ends. Depths are
// at most log2 of the reachable nodes (<= 10); each walk step is one RAM read.
// After reset a clearing pass restores every link and size before req_tready
// first rises. A stalled result holds the sequencer in its result state only
// if a second result is ready before the first is taken.
module weighted_union_find #(
   parameter int NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] first_node, [19:10] second_node
   input  logic        req_tuser,   // [0] kind
   // stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] same_set, [1] range_error
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import wuf_pkg::*;

   localparam int IDX_W = $clog2(NODES);

   // sequencer and working registers
   state_type          state_ff,   state_in;
   logic [IDX_W-1:0]   clr_ff,     clr_in;
   logic               kind_ff,    kind_in;
   logic [IDX_W-1:0]   node_b_ff,  node_b_in;
   logic [IDX_W-1:0]   cur_ff,     cur_in;
   logic [IDX_W-1:0]   root_a_ff,  root_a_in;
   logic [IDX_W-1:0]   root_b_ff,  root_b_in;
   logic [SIZE_W-1:0]  size_a_ff,  size_a_in;
   logic               res_same_ff, res_same_in;
   logic               res_err_ff,  res_err_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_same_ff,  rsp_same_in;
   logic               rsp_err_ff,   rsp_err_in;

   logic [COUNT_W-1:0] node_count_ff, node_count_in;

   // RAM ports
   logic               par_wr_en;
   logic [IDX_W-1:0]   par_wr_addr, par_wr_data, par_rd_addr, par_q;
   logic               siz_wr_en;
   logic [IDX_W-1:0]   siz_wr_addr, siz_rd_addr;
   logic [SIZE_W-1:0]  siz_wr_data, siz_q;

   logic [NODE_W-1:0]  req_first, req_second;
   logic               range_err;
   logic               link_is_root;
   logic               out_free;
   logic               csr_write;
   logic [SIZE_W-1:0]  size_sum;

   assign req_first  = req_tdata[NODE_W-1:0];
   assign req_second = req_tdata[2*NODE_W-1:NODE_W];

   // limit is min(node_count, NODES)
   assign range_err = ({1'b0, req_first}  >= node_count_ff)
                   || ({1'b0, req_second} >= node_count_ff)
                   || (32'(req_first)  >= 32'(NODES))
                   || (32'(req_second) >= 32'(NODES));

   // the one shared comparator of the walk: does the node link to itself
   assign link_is_root = (par_q == cur_ff);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign size_sum     = size_a_ff + siz_q;

   wuf_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_addr (par_rd_addr),
      .rd_data (par_q)
   );

   wuf_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size (
      .clock   (clock),
      .wr_en   (siz_wr_en),
      .wr_addr (siz_wr_addr),
      .wr_data (siz_wr_data),
      .rd_addr (siz_rd_addr),
      .rd_data (siz_q)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      kind_in     = kind_ff;
      node_b_in   = node_b_ff;
      cur_in      = cur_ff;
      root_a_in   = root_a_ff;
      root_b_in   = root_b_ff;
      size_a_in   = size_a_ff;
      res_same_in = res_same_ff;
      res_err_in  = res_err_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_same_in  = rsp_same_ff;
      rsp_err_in   = rsp_err_ff;

      par_wr_en   = 1'b0;
      par_wr_addr = root_a_ff;
      par_wr_data = root_b_ff;
      par_rd_addr = cur_ff;
      siz_wr_en   = 1'b0;
      siz_wr_addr = root_b_ff;
      siz_wr_data = size_sum;
      siz_rd_addr = root_a_ff;

      case (state_ff)
         ST_CLEAR: begin
            // every node its own root, every tree of size one
            par_wr_en   = 1'b1;
            par_wr_addr = clr_ff;
            par_wr_data = clr_ff;
            siz_wr_en   = 1'b1;
            siz_wr_addr = clr_ff;
            siz_wr_data = SIZE_W'(1);
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               node_b_in = IDX_W'(req_second);
               if (range_err) begin
                  res_same_in = 1'b0;
                  res_err_in  = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  cur_in      = IDX_W'(req_first);
                  par_rd_addr = IDX_W'(req_first);
                  state_in    = ST_WALK_A;
               end
            end
         end
         ST_WALK_A: begin
            if (link_is_root) begin
               root_a_in   = cur_ff;
               cur_in      = node_b_ff;
               par_rd_addr = node_b_ff;
               state_in    = ST_WALK_B;
            end else begin
               cur_in      = par_q;
               par_rd_addr = par_q;
            end
         end
         ST_WALK_B: begin
            if (link_is_root) begin
               root_b_in   = cur_ff;
               res_same_in = (cur_ff == root_a_ff);
               res_err_in  = 1'b0;
               siz_rd_addr = root_a_ff;
               if (kind_ff == KIND_QUERY || cur_ff == root_a_ff) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SIZE_A;
               end
            end else begin
               cur_in      = par_q;
               par_rd_addr = par_q;
            end
         end
         ST_SIZE_A: begin
            size_a_in   = siz_q;
            siz_rd_addr = root_b_ff;
            state_in    = ST_SIZE_B;
         end
         ST_SIZE_B: begin
            // smaller tree goes under; on a tie the first root moves
            par_wr_en = 1'b1;
            siz_wr_en = 1'b1;
            if (size_a_ff <= siz_q) begin
               par_wr_addr = root_a_ff;
               par_wr_data = root_b_ff;
               siz_wr_addr = root_b_ff;
            end else begin
               par_wr_addr = root_b_ff;
               par_wr_data = root_a_ff;
               siz_wr_addr = root_a_ff;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_same_in  = res_same_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration: one word, byte offset ignored
   assign csr_write     = csr_psel && csr_penable && csr_pwrite;
   assign node_count_in = csr_write ? csr_pwdata[COUNT_W-1:0] : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      node_b_ff   <= node_b_in;
      cur_ff      <= cur_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      size_a_ff   <= size_a_in;
      res_same_ff <= res_same_in;
      res_err_ff  <= res_err_in;
      rsp_same_ff <= rsp_same_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_err_ff, rsp_same_ff};
   assign csr_prdata = {{(32 - COUNT_W){1'b0}}, node_count_ff};
   assign csr_pready = 1'b1;

   // ---- assertions ----
`include "weighted_union_find_assert.svh"

   // a link write never makes a root point at itself
   `WUF_ASSERT_NOW(a_no_self_link, clock, reset,
      par_wr_en && state_ff == ST_SIZE_B, par_wr_addr != par_wr_data)
   // a rejected item never reports a shared root
   `WUF_ASSERT_NOW(a_err_not_same, clock, reset,
      rsp_valid_ff && rsp_err_ff, !rsp_same_ff)
   // one item at a time: ready drops after a transfer in
   `WUF_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready, !req_tready)
   // a waiting result is not overwritten by the next one
   `WUF_ASSERT_NEXT(a_resp_holds, clock, reset,
      state_ff == ST_RESP && rsp_valid_ff && !rsp_tready, state_ff == ST_RESP)

endmodule
